// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked concurrent assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/bse_pkg.sv =====
// ----------------------------------------------------------------------------
// Bubble sort engine package
// Widths and default sizes shared by the sort engine and its checker.
// ----------------------------------------------------------------------------
package bse_pkg;

	// Width of one element of the set.
	localparam int unsigned ELEM_W = 32;

	// Default capacity of the element store.
	localparam int unsigned DEPTH_DEFAULT = 16;

endpackage

// ===== hdl/bse_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module bse_ram #(
	parameter int unsigned WIDTH  = 32,
	parameter int unsigned DEPTH  = 16,
	parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== hdl/bubble_sort_engine_unit.sv =====
// ----------------------------------------------------------------------------
// Bubble sort engine
// Loading never stalls the sender, and a new set is taken only once the last
// result of the previous set has gone out. A set is sorted by repeated passes
// and streamed out one result at a time, at a pace set by the single compare-and-swap
// unit and the one read and one write port of the element store.
// Reset clears the count, the overflow flag and the order bit; store is not cleared.
// ----------------------------------------------------------------------------
module bubble_sort_engine_unit #(
	parameter int unsigned DEPTH = bse_pkg::DEPTH_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic                              cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [bse_pkg::ELEM_W-1:0] element_value,
	input  logic                              last_element,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [bse_pkg::ELEM_W-1:0] sorted_value,
	output logic                              last_result,
	output logic                              items_dropped
);

	import bse_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 2);

	// Sequencer states.
	localparam logic [2:0] ST_LOAD     = 3'd0;
	localparam logic [2:0] ST_PRIME    = 3'd1;
	localparam logic [2:0] ST_FIRST    = 3'd2;
	localparam logic [2:0] ST_SCAN     = 3'd3;
	localparam logic [2:0] ST_FLUSH    = 3'd4;
	localparam logic [2:0] ST_OUT_RD   = 3'd5;
	localparam logic [2:0] ST_OUT_LD   = 3'd6;
	localparam logic [2:0] ST_OUT_HOLD = 3'd7;

	logic [2:0]              state_q;
	logic [CW-1:0]           count_q;
	logic                    overflow_q;
	logic                    sort_descending_q;
	logic [CW-1:0]           pass_q;
	logic [CW-1:0]           rd_idx_q;
	logic [AW-1:0]           wr_idx_q;
	logic [AW-1:0]           out_idx_q;
	logic signed [ELEM_W-1:0] carry_q;
	logic                    out_valid_q;
	logic signed [ELEM_W-1:0] out_value_q;
	logic                    out_last_q;
	logic                    out_dropped_q;

	logic                    in_xfer;
	logic                    out_xfer;
	logic                    has_room;
	logic [CW-1:0]           count_next;
	logic signed [ELEM_W-1:0] scan_y;
	logic signed [ELEM_W-1:0] cmp_a;
	logic signed [ELEM_W-1:0] cmp_b;
	logic                    swap;
	logic                    is_last_out;

	logic                    ram_wr_en;
	logic [AW-1:0]           ram_wr_addr;
	logic [ELEM_W-1:0]       ram_wr_data;
	logic                    ram_rd_en;
	logic [AW-1:0]           ram_rd_addr;
	logic [ELEM_W-1:0]       ram_rd_data;

	// Handshake and bookkeeping.
	assign in_stall    = (state_q != ST_LOAD);
	assign in_xfer     = in_valid && !in_stall;
	assign out_xfer    = out_valid_q && !out_stall;
	assign has_room    = (count_q < CW'(DEPTH));
	assign count_next  = has_room ? (count_q + CW'(1)) : count_q;
	assign is_last_out = ((CW'(out_idx_q) + CW'(1)) == count_q);

	// Shared compare unit: the operands are swapped for descending order, so
	// one signed greater-than decides every exchange. Equal values never swap.
	assign scan_y = signed'(ram_rd_data);
	assign cmp_a  = sort_descending_q ? scan_y : carry_q;
	assign cmp_b  = sort_descending_q ? carry_q : scan_y;
	assign swap   = (cmp_a > cmp_b);

	// Store port steering for each sequencer state.
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = '0;
		ram_wr_data = carry_q;
		ram_rd_en   = 1'b0;
		ram_rd_addr = '0;
		unique case (state_q)
			ST_LOAD: begin
				ram_wr_en   = in_xfer && has_room;
				ram_wr_addr = count_q[AW-1:0];
				ram_wr_data = element_value;
			end
			ST_PRIME: begin
				ram_rd_en   = 1'b1;
				ram_rd_addr = '0;
			end
			ST_FIRST: begin
				ram_rd_en   = 1'b1;
				ram_rd_addr = AW'(1);
			end
			ST_SCAN: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = wr_idx_q;
				ram_wr_data = swap ? scan_y : carry_q;
				ram_rd_en   = (rd_idx_q < count_q);
				ram_rd_addr = rd_idx_q[AW-1:0];
			end
			ST_FLUSH: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = AW'(count_q - CW'(1));
			end
			ST_OUT_RD: begin
				ram_rd_en   = 1'b1;
				ram_rd_addr = out_idx_q;
			end
			ST_OUT_LD: begin
				ram_rd_en   = 1'b0;
			end
			ST_OUT_HOLD: begin
				ram_rd_en   = out_xfer && !out_last_q;
				ram_rd_addr = out_idx_q + AW'(1);
			end
		endcase
	end

	// Sequencer and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_LOAD;
			count_q           <= '0;
			overflow_q        <= 1'b0;
			sort_descending_q <= 1'b0;
			pass_q            <= '0;
			rd_idx_q          <= '0;
			wr_idx_q          <= '0;
			out_idx_q         <= '0;
			out_valid_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				sort_descending_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_xfer) begin
						count_q <= count_next;
						if (!has_room) begin
							overflow_q <= 1'b1;
						end
						if (last_element) begin
							pass_q    <= '0;
							out_idx_q <= '0;
							state_q   <= (count_next == CW'(1)) ? ST_OUT_RD : ST_PRIME;
						end
					end
				end
				ST_PRIME: begin
					state_q <= ST_FIRST;
				end
				ST_FIRST: begin
					rd_idx_q <= CW'(2);
					wr_idx_q <= '0;
					state_q  <= ST_SCAN;
				end
				ST_SCAN: begin
					rd_idx_q <= rd_idx_q + CW'(1);
					wr_idx_q <= wr_idx_q + AW'(1);
					if ((CW'(wr_idx_q) + CW'(2)) == count_q) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					pass_q  <= pass_q + CW'(1);
					state_q <= ((pass_q + CW'(2)) == count_q) ? ST_OUT_RD : ST_PRIME;
				end
				ST_OUT_RD: begin
					state_q <= ST_OUT_LD;
				end
				ST_OUT_LD: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_OUT_HOLD;
				end
				ST_OUT_HOLD: begin
					if (out_xfer) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							count_q    <= '0;
							overflow_q <= 1'b0;
							state_q    <= ST_LOAD;
						end else begin
							out_idx_q <= out_idx_q + AW'(1);
							state_q   <= ST_OUT_LD;
						end
					end
				end
			endcase
		end
	end

	// Datapath registers: the bubbling element and the output register.
	always_ff @(posedge clk) begin
		if (state_q == ST_FIRST) begin
			carry_q <= scan_y;
		end else if (state_q == ST_SCAN && !swap) begin
			carry_q <= scan_y;
		end
		if (state_q == ST_OUT_LD) begin
			out_value_q   <= scan_y;
			out_last_q    <= is_last_out;
			out_dropped_q <= overflow_q;
		end
	end

	// Element store.
	bse_ram #(
		.WIDTH  (ELEM_W),
		.DEPTH  (DEPTH),
		.ADDR_W (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	assign out_valid     = out_valid_q;
	assign sorted_value  = out_value_q;
	assign last_result   = out_last_q;
	assign items_dropped = out_dropped_q;

endmodule

// ===== hdl/bse_checker.sv =====
// ----------------------------------------------------------------------------
// Bubble sort engine checker
// Port-level properties of the sort engine, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bse_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              last_element,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic signed [bse_pkg::ELEM_W-1:0] sorted_value,
	input logic                              last_result
);

	// A stalled result holds its value.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(sorted_value), "stalled result changed")

	// Loading and emitting never overlap.
	`ASSERT_SAME(a_no_overlap, clk, arst_n, !in_stall, !out_valid, "result offered while loading")

	// The closing transfer stops further loading at once.
	`ASSERT_NEXT(a_close_stalls, clk, arst_n, in_valid && !in_stall && last_element, in_stall, "input taken after set closed")

	// After the final result of a set, no result is offered in the next cycle.
	`ASSERT_NEXT(a_last_ends, clk, arst_n, out_valid && !out_stall && last_result, !out_valid, "result after final one")

endmodule

bind bubble_sort_engine_unit bse_checker u_bse_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.last_element (last_element),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.sorted_value (sorted_value),
	.last_result  (last_result)
);

// ===== tb/tb_bubble_sort_engine_unit.sv =====
// ----------------------------------------------------------------------------
// Bubble sort engine testbench
// Loads sets of signed elements into the sort engine and checks every sorted
// result against an in-bench model of the store, the order bit and the
// overflow flag. Directed sets cover single elements, extreme values and a
// full store; random sets of varied shape follow in both orders. The sender
// idles in bursts and the receiver stalls on a changing pattern.
// ----------------------------------------------------------------------------
module tb_bubble_sort_engine_unit;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SET_DEPTH     = bse_pkg::DEPTH_DEFAULT;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned LIMIT_CYCLES  = 400000;
	localparam int unsigned REPORT_LINES  = 100;

	typedef logic signed [bse_pkg::ELEM_W-1:0] elem_t;

	typedef struct packed {
		elem_t value;
		logic  last;
		logic  dropped;
	} sorted_result_t;

	typedef enum int unsigned {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	typedef enum int unsigned {
		SHAPE_RANDOM,
		SHAPE_NARROW,
		SHAPE_EXTREME,
		SHAPE_ASCENDING,
		SHAPE_DESCENDING
	} set_shape_t;

	logic  clk;
	logic  arst_n;
	logic  cfg_we;
	logic  cfg_wdata;
	logic  in_valid;
	logic  in_stall;
	elem_t element_value;
	logic  last_element;
	logic  out_valid;
	logic  out_stall;
	elem_t sorted_value;
	logic  last_result;
	logic  items_dropped;

	// Model of the engine: held elements, their count, the overflow flag and the order.
	elem_t          held_set [SET_DEPTH];
	int unsigned    held_count;
	bit             overflow_flag;
	bit             descending_order;
	sorted_result_t sorted_queue [$];

	int unsigned error_count;
	int unsigned burst_left;
	bit          gaps_enabled;
	stall_mode_t stall_mode;
	int unsigned stall_left;
	int unsigned stall_phase;

	bubble_sort_engine_unit #(
		.DEPTH(SET_DEPTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.element_value(element_value),
		.last_element (last_element),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sorted_value (sorted_value),
		.last_result  (last_result),
		.items_dropped(items_dropped)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Absolute limit on the run, far beyond the slowest correct run.
	initial begin
		#(LIMIT_CYCLES * 20);
		$display("bubble_sort_engine_unit: mismatch");
		$finish;
	end

	// Prints one line per mismatch, up to a cap, and counts every one.
	task automatic report_mismatch(input string what, input longint got, input longint want);
		error_count++;
		if (error_count <= REPORT_LINES) begin
			$display("%0t: sorted result error, %s: got %0d, expected %0d",
				$realtime, what, got, want);
		end
	endtask

	// Stores one accepted element, or flags overflow when full, and when it closes
	// the set sorts it and queues the expected results. Equal neighbours stay put.
	function automatic void predict_sorted(input elem_t value, input logic closing);
		elem_t          swap_tmp;
		sorted_result_t res;
		if (held_count < SET_DEPTH) begin
			held_set[held_count] = value;
			held_count++;
		end else begin
			overflow_flag = 1'b1;
		end
		if (!closing) return;
		for (int unsigned pass = 0; pass + 1 < held_count; pass++) begin
			for (int unsigned i = 0; i + 1 < held_count; i++) begin
				if (descending_order ? (held_set[i + 1] > held_set[i])
						: (held_set[i] > held_set[i + 1])) begin
					swap_tmp        = held_set[i];
					held_set[i]     = held_set[i + 1];
					held_set[i + 1] = swap_tmp;
				end
			end
		end
		for (int unsigned k = 0; k < held_count; k++) begin
			res.value   = held_set[k];
			res.last    = (k + 1 == held_count);
			res.dropped = overflow_flag;
			sorted_queue.push_back(res);
		end
		held_count    = 0;
		overflow_flag = 1'b0;
	endfunction

	// Offers one element and waits for its transfer. A burst of transfers may
	// be preceded by a random gap; valid stays high between items of a burst.
	task automatic send_element(input elem_t value, input logic closing);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = gaps_enabled ? $urandom_range(0, 6) : 0;
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid      <= 1'b1;
		element_value <= value;
		last_element  <= closing;
		do @(posedge clk); while (in_stall);
		predict_sorted(value, closing);
	endtask

	// Holds the sender off until every expected result has arrived, then lets
	// the engine settle.
	task automatic wait_sort_idle();
		in_valid <= 1'b0;
		while (sorted_queue.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the order bit; only called while the engine is idle.
	task automatic set_sort_order(input bit descending);
		cfg_we    <= 1'b1;
		cfg_wdata <= descending;
		@(posedge clk);
		cfg_we           <= 1'b0;
		descending_order = descending;
	endtask

	function automatic int extreme_value();
		case ($urandom_range(0, 6))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return 32'sh8000_0001;
			3:       return 32'sh7fff_fffe;
			4:       return -1;
			5:       return 1;
			default: return 0;
		endcase
	endfunction

	// Builds one set of random size and shape and sends it; returns how many
	// of its elements fit in the store.
	task automatic send_random_set(output int unsigned stored);
		int         vals [];
		int         n;
		set_shape_t shape;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(SET_DEPTH + 1, SET_DEPTH + 4)
			: $urandom_range(1, SET_DEPTH);
		shape = set_shape_t'($urandom_range(SHAPE_RANDOM, SHAPE_DESCENDING));
		vals = new[n];
		foreach (vals[i]) begin
			case (shape)
				SHAPE_NARROW:  vals[i] = $urandom_range(0, 6) - 3;
				SHAPE_EXTREME: vals[i] = extreme_value();
				default:       vals[i] = $urandom;
			endcase
		end
		if (shape == SHAPE_ASCENDING) vals.sort();
		if (shape == SHAPE_DESCENDING) vals.rsort();
		gaps_enabled = ($urandom_range(0, 3) != 0);
		foreach (vals[i]) send_element(vals[i], i == n - 1);
		stored = (n > SET_DEPTH) ? SET_DEPTH : n;
	endtask

	task automatic run_random_sets(input int unsigned target);
		int unsigned stored_total;
		int unsigned stored;
		stored_total = 0;
		while (stored_total < target) begin
			send_random_set(stored);
			stored_total += stored;
			if ($urandom_range(0, 11) == 0) wait_sort_idle();
		end
	endtask

	// A lone element comes back unchanged and marked last.
	task automatic test_single_element();
		send_element(32'sh8000_0000, 1'b1);
		wait_sort_idle();
	endtask

	// Extreme values in both orders.
	task automatic test_extreme_values();
		send_element(32'sh7fff_ffff, 1'b0);
		send_element(32'sh8000_0000, 1'b0);
		send_element(0, 1'b0);
		send_element(-1, 1'b1);
		wait_sort_idle();
		set_sort_order(1'b1);
		send_element(-1, 1'b0);
		send_element(32'sh8000_0000, 1'b0);
		send_element(32'sh7fff_ffff, 1'b0);
		send_element(1, 1'b1);
		wait_sort_idle();
	endtask

	// A full store whose closing element is discarded but still closes the set.
	task automatic test_store_overflow();
		for (int unsigned i = 0; i < SET_DEPTH; i++) begin
			send_element($urandom, 1'b0);
		end
		send_element(32'sh7fff_ffff, 1'b1);
		wait_sort_idle();
	endtask

	// Compares each result transfer with the oldest expected result.
	always @(posedge clk) begin : check_results
		sorted_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (sorted_queue.size() == 0) begin
				report_mismatch("unexpected result, sorted_value", sorted_value, 0);
			end else begin
				want = sorted_queue.pop_front();
				if (sorted_value !== want.value)
					report_mismatch("sorted_value", sorted_value, want.value);
				if (last_result !== want.last)
					report_mismatch("last_result", last_result, want.last);
				if (items_dropped !== want.dropped)
					report_mismatch("items_dropped", items_dropped, want.dropped);
			end
		end
	end

	// Receiver stall pattern: modes of random length, including stretches
	// with no stall at all.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_PERIODIC));
			stall_left = $urandom_range(20, 120);
		end else begin
			stall_left--;
		end
		stall_phase++;
		case (stall_mode)
			STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
			STALL_PERIODIC: out_stall <= (stall_phase % 3 == 0);
			default:        out_stall <= 1'b0;
		endcase
	end

	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = 1'b0;
		in_valid         = 1'b0;
		element_value    = '0;
		last_element     = 1'b0;
		out_stall        = 1'b0;
		held_count       = 0;
		overflow_flag    = 1'b0;
		descending_order = 1'b0;
		error_count      = 0;
		burst_left       = 0;
		gaps_enabled     = 1'b1;
		stall_mode       = STALL_NONE;
		stall_left       = 0;
		stall_phase      = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_element();
		test_extreme_values();
		test_store_overflow();
		set_sort_order(1'b0);
		run_random_sets(96);
		wait_sort_idle();
		set_sort_order(1'b1);
		run_random_sets(96);
		wait_sort_idle();
		set_sort_order(1'b0);
		run_random_sets(96);
		wait_sort_idle();

		if (error_count == 0) begin
			$display("bubble_sort_engine_unit: match");
		end else begin
			$display("bubble_sort_engine_unit: mismatch");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/bse_pkg.sv
hdl/bse_ram.sv
hdl/bubble_sort_engine_unit.sv
hdl/bse_checker.sv
tb/tb_bubble_sort_engine_unit.sv
